// File: rtl/smrc_pkg.sv
// Package for the servo motion ramp controller: codes, table entry and word types.
// Shared by the step logic, the top level and the testbench. No dependencies.
package smrc_pkg;

   // Channel table size
   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MAX_RESULTS  = 3;

   // Configuration register indexes
   localparam logic CSR_SPEED_PIVOT  = 1'b0;
   localparam logic CSR_CUTOFF_POLLS = 1'b1;

   // Configuration reset values
   localparam logic [7:0] SPEED_PIVOT_RST  = 8'd128;
   localparam logic [7:0] CUTOFF_POLLS_RST = 8'd10;

   // Pulse width scaling: ticks = offset + slope * position
   localparam logic [15:0] PW_STD_OFFSET = 16'd3600;
   localparam logic [15:0] PW_STD_SLOPE  = 16'd19;
   localparam logic [15:0] PW_EXT_OFFSET = 16'd1400;
   localparam logic [15:0] PW_EXT_SLOPE  = 16'd36;
   localparam logic [15:0] PW_RELOAD_TOP = 16'hFFFF;
   localparam logic [7:0]  POS_MAX       = 8'd255;

   typedef enum logic [1:0] {
      REQ_POLL   = 2'd0,
      REQ_MOVE   = 2'd1,
      REQ_SETPOS = 2'd2,
      REQ_PULSE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_AT_START = 2'd0,
      KIND_AT_END   = 2'd1,
      KIND_MIDWAY   = 2'd2,
      KIND_PULSE    = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      MS_OFF      = 2'd0,
      MS_STARTING = 2'd1,
      MS_MOVING   = 2'd2,
      MS_STOPPED  = 2'd3
   } motion_state_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_LOOK = 1'b1
   } ctl_state_type;

   // Per-channel table entry; all-zero is the reset entry
   typedef struct packed {
      logic [7:0] cur_pos;
      logic [7:0] tgt_pos;
      logic [1:0] motion_state;
      logic [7:0] steps_per_poll;
      logic [7:0] polls_per_step;
      logic [7:0] poll_counter;
      logic [7:0] stopped_polls;
      logic [7:0] chan_start_pos;
      logic [7:0] chan_end_pos;
      logic       fl_ext;
      logic       fl_cutoff;
      logic       fl_evinv;
   } chan_entry_type;

   // Accepted request word
   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] channel;
      logic       action_on;
      logic [7:0] start_pos;
      logic [7:0] end_pos;
      logic [7:0] speed_start_to_end;
      logic [7:0] speed_end_to_start;
      logic       trigger_inverted;
      logic       event_inverted;
      logic       cutoff_enable;
      logic       extended_travel;
      logic [7:0] position;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [3:0]  out_channel;
      logic [1:0]  result_kind;
      logic        evt_polarity;
      logic        save_position;
      logic [7:0]  current_position;
      logic [15:0] pulse_reload;
      logic        pulse_enable;
      logic        last;
   } rsp_word_type;

   // Step logic status back to the top level
   typedef struct packed {
      chan_entry_type entry;
      logic           wr_en;
      logic [1:0]     count;
   } step_status_type;

endpackage

// File: rtl/smrc_ifs.sv
// Handshake interfaces of the servo motion ramp controller: request, response, CSR.
// Depends on nothing; widths follow the fixed field widths.
interface smrc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [3:0] channel;
   logic       action_on;
   logic [7:0] start_pos;
   logic [7:0] end_pos;
   logic [7:0] speed_start_to_end;
   logic [7:0] speed_end_to_start;
   logic       trigger_inverted;
   logic       event_inverted;
   logic       cutoff_enable;
   logic       extended_travel;
   logic [7:0] position;

   modport source (output valid, req_type, channel, action_on, start_pos, end_pos,
                   speed_start_to_end, speed_end_to_start, trigger_inverted,
                   event_inverted, cutoff_enable, extended_travel, position,
                   input ready);
   modport sink   (input valid, req_type, channel, action_on, start_pos, end_pos,
                   speed_start_to_end, speed_end_to_start, trigger_inverted,
                   event_inverted, cutoff_enable, extended_travel, position,
                   output ready);
endinterface

interface smrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  out_channel;
   logic [1:0]  result_kind;
   logic        evt_polarity;
   logic        save_position;
   logic [7:0]  current_position;
   logic [15:0] pulse_reload;
   logic        pulse_enable;
   logic        last;

   modport source (output valid, out_channel, result_kind, evt_polarity, save_position,
                   current_position, pulse_reload, pulse_enable, last,
                   input ready);
   modport sink   (input valid, out_channel, result_kind, evt_polarity, save_position,
                   current_position, pulse_reload, pulse_enable, last,
                   output ready);
endinterface

interface smrc_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/servo_motion_ramp_controller.sv
// Servo motion ramp controller top level: channel table memory, control, response queue.
// Depends on smrc_pkg, smrc_ifs and smrc_step.
// Each request word is read from the table into a register, then modified and written back;
// its response words go into the queue register at write-back. No new word is taken before
// then, and every word waits in write-back until all earlier response words have been taken.
// Reset: synchronous; clears control, configuration and the entry valid bits (no clear pass).
module servo_motion_ramp_controller (
   input logic        clock,
   input logic        reset,
   smrc_req_if.sink   req_if,
   smrc_rsp_if.source rsp_if,
   smrc_csr_if.sink   csr_if
);
   import smrc_pkg::*;

   ctl_state_type   state_ff;
   ctl_state_type   state_in;
   logic [7:0]      speed_pivot_ff;
   logic [7:0]      cutoff_polls_ff;
   req_word_type    item_ff;
   req_word_type    item_word;
   chan_entry_type  chan_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   chan_entry_type  rd_entry_ff;
   logic            rd_valid_ff;
   chan_entry_type  cur_entry;
   step_status_type status;
   rsp_word_type    res [MAX_RESULTS];
   rsp_word_type    queue_ff [MAX_RESULTS];
   logic [1:0]      count_ff;
   logic            req_accept;
   logic            rsp_pop;
   logic            commit;
   logic            chan_ok;
   logic [CHAN_AW-1:0] rd_idx;
   logic [CHAN_AW-1:0] wr_idx;

   // Request word packing
   always_comb begin
      item_word.req_type           = req_if.req_type;
      item_word.channel            = req_if.channel;
      item_word.action_on          = req_if.action_on;
      item_word.start_pos          = req_if.start_pos;
      item_word.end_pos            = req_if.end_pos;
      item_word.speed_start_to_end = req_if.speed_start_to_end;
      item_word.speed_end_to_start = req_if.speed_end_to_start;
      item_word.trigger_inverted   = req_if.trigger_inverted;
      item_word.event_inverted     = req_if.event_inverted;
      item_word.cutoff_enable      = req_if.cutoff_enable;
      item_word.extended_travel    = req_if.extended_travel;
      item_word.position           = req_if.position;
   end

   assign req_if.ready = (state_ff == CTL_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_pop      = rsp_if.valid && rsp_if.ready;
   assign commit       = (state_ff == CTL_LOOK) && (count_ff == 2'd0);
   assign rd_idx       = CHAN_AW'(req_if.channel);
   assign wr_idx       = CHAN_AW'(item_ff.channel);
   assign chan_ok      = (int'(item_ff.channel) < NUM_CHANNELS);

   // Configuration registers
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_pivot_ff  <= SPEED_PIVOT_RST;
         cutoff_polls_ff <= CUTOFF_POLLS_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_SPEED_PIVOT:  speed_pivot_ff  <= csr_if.data;
            CSR_CUTOFF_POLLS: cutoff_polls_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: if (req_accept) state_in = CTL_LOOK;
         CTL_LOOK: if (commit)     state_in = CTL_IDLE;
         default:  state_in = CTL_IDLE;
      endcase
   end

   // Request word register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_word;
      end
   end

   // Channel table: read on accept, write back on commit
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_entry_ff <= chan_mem[rd_idx];
      end
      if (commit && chan_ok && status.wr_en) begin
         chan_mem[wr_idx] <= status.entry;
      end
   end

   // Entry valid bits; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
         if (commit && chan_ok && status.wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   assign cur_entry = rd_valid_ff ? rd_entry_ff : '0;

   smrc_step u_step (
      .item         (item_ff),
      .ent          (cur_entry),
      .speed_pivot  (speed_pivot_ff),
      .cutoff_polls (cutoff_polls_ff),
      .status       (status),
      .res          (res)
   );

   // Response queue: loaded only when empty, drained from the head
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (commit) begin
         count_ff <= chan_ok ? status.count : 2'd0;
      end else if (rsp_pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            queue_ff[i] <= res[i];
         end
      end else if (rsp_pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            queue_ff[i] <= queue_ff[i+1];
         end
      end
   end

   // Response port
   assign rsp_if.valid            = (count_ff != 2'd0);
   assign rsp_if.out_channel      = queue_ff[0].out_channel;
   assign rsp_if.result_kind      = queue_ff[0].result_kind;
   assign rsp_if.evt_polarity     = queue_ff[0].evt_polarity;
   assign rsp_if.save_position    = queue_ff[0].save_position;
   assign rsp_if.current_position = queue_ff[0].current_position;
   assign rsp_if.pulse_reload     = queue_ff[0].pulse_reload;
   assign rsp_if.pulse_enable     = queue_ff[0].pulse_enable;
   assign rsp_if.last             = queue_ff[0].last;

endmodule

// File: rtl/smrc_step.sv
// Step logic: works out the new table entry and up to three response words for one
// request word. Depends on smrc_pkg.
module smrc_step (
   input  smrc_pkg::req_word_type    item,
   input  smrc_pkg::chan_entry_type  ent,
   input  logic [7:0]                speed_pivot,
   input  logic [7:0]                cutoff_polls,
   output smrc_pkg::step_status_type status,
   output smrc_pkg::rsp_word_type    res [smrc_pkg::MAX_RESULTS]
);
   import smrc_pkg::*;

   logic [7:0]   midway;
   logic [7:0]   cnt_dec;
   logic         step_tick;
   logic [8:0]   up_sum;
   logic [7:0]   up_raw;
   logic [7:0]   up_new;
   logic [7:0]   dn_raw;
   logic [7:0]   dn_new;
   logic [7:0]   cur_new;
   logic [7:0]   cnt_new;
   logic         mid_hit;
   logic         mid_on;
   logic         going_up;
   logic         going_dn;
   logic [7:0]   stop_cnt;
   logic [7:0]   speed_sel;
   logic [15:0]  pos16;
   logic [15:0]  ticks;
   logic [7:0]   move_tgt;
   chan_entry_type nxt;
   logic         wr_en;
   rsp_word_type cand [MAX_RESULTS];
   logic [MAX_RESULTS-1:0] emit;
   logic [1:0]   res_n;

   // Midway between start and end, each halved first
   assign midway    = {1'b0, ent.chan_end_pos[7:1]} + {1'b0, ent.chan_start_pos[7:1]};
   assign going_up  = ent.tgt_pos > ent.cur_pos;
   assign going_dn  = ent.tgt_pos < ent.cur_pos;
   assign cnt_dec   = ent.poll_counter - 8'd1;
   assign step_tick = (cnt_dec == 8'd0);

   // Ramp upwards, clamped to full scale and target
   assign up_sum = {1'b0, ent.cur_pos} + {1'b0, ent.steps_per_poll};
   always_comb begin
      if (ent.steps_per_poll != 8'd0) begin
         up_raw = up_sum[8] ? POS_MAX : up_sum[7:0];
      end else if (step_tick && ent.cur_pos != POS_MAX) begin
         up_raw = ent.cur_pos + 8'd1;
      end else begin
         up_raw = ent.cur_pos;
      end
      up_new = (up_raw > ent.tgt_pos) ? ent.tgt_pos : up_raw;
   end

   // Ramp downwards, clamped to zero and target
   always_comb begin
      if (ent.steps_per_poll != 8'd0) begin
         dn_raw = (ent.steps_per_poll >= ent.cur_pos) ? 8'd0
                                                      : ent.cur_pos - ent.steps_per_poll;
      end else if (step_tick && ent.cur_pos != 8'd0) begin
         dn_raw = ent.cur_pos - 8'd1;
      end else begin
         dn_raw = ent.cur_pos;
      end
      dn_new = (dn_raw < ent.tgt_pos) ? ent.tgt_pos : dn_raw;
   end

   // Position, counter and midway crossing for a moving poll
   always_comb begin
      cur_new = ent.cur_pos;
      cnt_new = ent.poll_counter;
      mid_hit = 1'b0;
      mid_on  = ent.fl_evinv;
      if (going_up) begin
         cur_new = up_new;
         mid_hit = (up_new >= midway) && (ent.cur_pos < midway);
         mid_on  = ~ent.fl_evinv;
      end else if (going_dn) begin
         cur_new = dn_new;
         mid_hit = (dn_new <= midway) && (ent.cur_pos > midway);
      end
      if ((going_up || going_dn) && ent.steps_per_poll == 8'd0) begin
         cnt_new = step_tick ? ent.polls_per_step : cnt_dec;
      end
   end

   // Stopped-poll count, saturating
   assign stop_cnt  = (ent.stopped_polls != POS_MAX) ? ent.stopped_polls + 8'd1
                                                     : ent.stopped_polls;
   assign speed_sel = item.action_on ? item.speed_start_to_end : item.speed_end_to_start;
   assign move_tgt  = (item.action_on ^ item.trigger_inverted) ? item.end_pos
                                                               : item.start_pos;

   // Pulse width in timer ticks
   assign pos16 = {8'd0, ent.cur_pos};
   assign ticks = ent.fl_ext ? PW_EXT_OFFSET + pos16 * PW_EXT_SLOPE
                             : PW_STD_OFFSET + pos16 * PW_STD_SLOPE;

   // Entry update and candidate words per request kind
   always_comb begin
      nxt   = ent;
      wr_en = 1'b0;
      emit  = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         cand[i] = '0;
         cand[i].out_channel = item.channel;
      end
      case (req_kind_type'(item.req_type))
         REQ_POLL: begin
            wr_en = 1'b1;
            case (motion_state_type'(ent.motion_state))
               MS_STOPPED: begin
                  nxt.stopped_polls = stop_cnt;
                  if (ent.fl_cutoff && stop_cnt >= cutoff_polls) begin
                     nxt.motion_state = MS_OFF;
                  end
               end
               MS_OFF: begin
                  wr_en = 1'b0;
               end
               default: begin
                  // Start event on the first poll after a move
                  if (ent.motion_state == MS_STARTING) begin
                     emit[0] = 1'b1;
                     cand[0].result_kind = (ent.cur_pos == ent.chan_start_pos) ?
                                           KIND_AT_START : KIND_AT_END;
                     cand[0].evt_polarity = ent.fl_evinv;
                     cand[0].current_position = ent.cur_pos;
                     nxt.motion_state = MS_MOVING;
                  end
                  nxt.cur_pos      = cur_new;
                  nxt.poll_counter = cnt_new;
                  emit[1] = mid_hit;
                  cand[1].result_kind      = KIND_MIDWAY;
                  cand[1].evt_polarity     = mid_on;
                  cand[1].current_position = cur_new;
                  // Stop event when target reached
                  if (cur_new == ent.tgt_pos) begin
                     nxt.motion_state  = MS_STOPPED;
                     nxt.stopped_polls = 8'd0;
                     emit[2] = 1'b1;
                     cand[2].result_kind = (cur_new == ent.chan_start_pos) ?
                                           KIND_AT_START : KIND_AT_END;
                     cand[2].evt_polarity     = ~ent.fl_evinv;
                     cand[2].save_position    = 1'b1;
                     cand[2].current_position = cur_new;
                  end
               end
            endcase
         end
         REQ_MOVE: begin
            wr_en              = 1'b1;
            nxt.chan_start_pos = item.start_pos;
            nxt.chan_end_pos   = item.end_pos;
            nxt.fl_evinv       = item.event_inverted;
            nxt.fl_cutoff      = item.cutoff_enable;
            nxt.fl_ext         = item.extended_travel;
            nxt.tgt_pos        = move_tgt;
            if (speed_sel > speed_pivot) begin
               nxt.steps_per_poll = speed_sel - speed_pivot;
               nxt.polls_per_step = 8'd0;
            end else begin
               nxt.polls_per_step = speed_pivot - speed_sel + 8'd1;
               nxt.poll_counter   = 8'd1;
               nxt.steps_per_poll = 8'd0;
            end
            nxt.motion_state = MS_STARTING;
         end
         REQ_SETPOS: begin
            wr_en       = 1'b1;
            nxt.cur_pos = item.position;
            nxt.tgt_pos = item.position;
         end
         REQ_PULSE: begin
            emit[0] = 1'b1;
            cand[0].result_kind      = KIND_PULSE;
            cand[0].current_position = ent.cur_pos;
            cand[0].pulse_reload     = PW_RELOAD_TOP - ticks;
            cand[0].pulse_enable     = (ent.motion_state != MS_OFF);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Pack emitted words in order and mark the final one
   always_comb begin
      res_n = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (emit[i]) begin
            res[res_n] = cand[i];
            res_n      = res_n + 2'd1;
         end
      end
      if (res_n != 2'd0) begin
         res[res_n - 2'd1].last = 1'b1;
      end
   end

   assign status.entry = nxt;
   assign status.wr_en = wr_en;
   assign status.count = res_n;

endmodule

// File: verif/tb_servo_motion_ramp_controller.sv
// Self-checking testbench for servo_motion_ramp_controller: directed table, then random phases.
// A ramp predictor checks every response word. Needs rtl/smrc_pkg.sv, rtl/smrc_ifs.sv and the design files.
`timescale 1ns / 1ps

module tb_servo_motion_ramp_controller;
   import smrc_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_WORDS   = 90;
   localparam int NUM_PHASES    = 5;
   localparam int PRINT_CAP     = 100;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   smrc_req_if req_if();
   smrc_rsp_if rsp_if();
   smrc_csr_if csr_if();

   servo_motion_ramp_controller i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predictor copy of the configuration and the channel table
   logic [7:0]       cfg_pivot;
   logic [7:0]       cfg_cutoff;
   logic [7:0]       pos_now    [NUM_CHANNELS];
   logic [7:0]       pos_goal   [NUM_CHANNELS];
   motion_state_type mstate     [NUM_CHANNELS];
   logic [7:0]       step_inc   [NUM_CHANNELS];
   logic [7:0]       step_div   [NUM_CHANNELS];
   logic [7:0]       tick_cnt   [NUM_CHANNELS];
   logic [7:0]       idle_polls [NUM_CHANNELS];
   logic [7:0]       home_pos   [NUM_CHANNELS];
   logic [7:0]       far_pos    [NUM_CHANNELS];
   logic             fl_evinv   [NUM_CHANNELS];
   logic             fl_cutoff  [NUM_CHANNELS];
   logic             fl_ext     [NUM_CHANNELS];

   rsp_word_type step_out[$];     // words caused by the request being modelled
   rsp_word_type pending_rsp[$];  // expected response words, oldest first
   dir_row_type  dir_rows[$];

   int  errors;
   int  n_rsp;
   int  cycles;
   bit  quiet;
   int  hold_rsp;
   logic [3:0] hot [4];

   rsp_word_type got;
   rsp_word_type want_now;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_servo_motion_ramp_controller failed");
         $finish;
      end
   end

   task automatic report(input string msg);
      if (errors < PRINT_CAP) $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got_v, input int want_v);
      if (got_v != want_v)
         report($sformatf("word %0d %s: got %0d, want %0d", n_rsp, name, got_v, want_v));
   endtask

   function automatic rsp_word_type mk_rsp(input int ch, input result_kind_type kind,
                                           input bit on, input bit save, input int pos,
                                           input int reload, input bit en,
                                           input bit fin = 1'b0);
      rsp_word_type r;
      r.out_channel      = 4'(ch);
      r.result_kind      = kind;
      r.evt_polarity     = on;
      r.save_position    = save;
      r.current_position = 8'(pos);
      r.pulse_reload     = 16'(reload);
      r.pulse_enable     = en;
      r.last             = fin;
      return r;
   endfunction

   function automatic req_word_type mk_req(input req_kind_type kind, input int ch,
                                           input int on, input int st, input int en,
                                           input int s_on, input int s_off, input int trig,
                                           input int evi, input int cut, input int ext,
                                           input int pos);
      req_word_type w;
      w.req_type           = kind;
      w.channel            = 4'(ch);
      w.action_on          = 1'(on);
      w.start_pos          = 8'(st);
      w.end_pos            = 8'(en);
      w.speed_start_to_end = 8'(s_on);
      w.speed_end_to_start = 8'(s_off);
      w.trigger_inverted   = 1'(trig);
      w.event_inverted     = 1'(evi);
      w.cutoff_enable      = 1'(cut);
      w.extended_travel    = 1'(ext);
      w.position           = 8'(pos);
      return w;
   endfunction

   task automatic add_row(input req_word_type w, input bit typed, input rsp_word_type want);
      dir_row_type row;
      row.w     = w;
      row.typed = typed;
      row.want  = want;
      dir_rows.push_back(row);
   endtask

   // One poll tick: events on starting, ramp with clamping, midway crossing, stop, cutoff
   task automatic ramp_poll(input int c);
      int cur;
      int goal;
      int mid;
      bit ev;
      bit short_of_mid;
      ev  = fl_evinv[c];
      mid = int'(far_pos[c]) / 2 + int'(home_pos[c]) / 2;
      if (mstate[c] == MS_STOPPED) begin
         if (idle_polls[c] != 8'd255) idle_polls[c] = idle_polls[c] + 8'd1;
         if (fl_cutoff[c] && idle_polls[c] >= cfg_cutoff) mstate[c] = MS_OFF;
         return;
      end
      if (mstate[c] == MS_OFF) return;
      if (mstate[c] == MS_STARTING) begin
         step_out.push_back(mk_rsp(c, (pos_now[c] == home_pos[c]) ? KIND_AT_START : KIND_AT_END,
                                   ev, 1'b0, int'(pos_now[c]), 0, 1'b0));
         mstate[c] = MS_MOVING;
      end
      cur  = int'(pos_now[c]);
      goal = int'(pos_goal[c]);
      if (goal > cur) begin
         short_of_mid = cur < mid;
         if (step_inc[c] != 0) begin
            cur = cur + int'(step_inc[c]);
            if (cur > 255) cur = 255;
         end else begin
            tick_cnt[c] = tick_cnt[c] - 8'd1;
            if (tick_cnt[c] == 8'd0) begin
               if (cur < 255) cur++;
               tick_cnt[c] = step_div[c];
            end
         end
         if (cur > goal) cur = goal;
         pos_now[c] = 8'(cur);
         if (cur >= mid && short_of_mid)
            step_out.push_back(mk_rsp(c, KIND_MIDWAY, ~ev, 1'b0, cur, 0, 1'b0));
      end else if (goal < cur) begin
         short_of_mid = cur > mid;
         if (step_inc[c] != 0) begin
            if (int'(step_inc[c]) >= cur) cur = 0;
            else cur = cur - int'(step_inc[c]);
         end else begin
            tick_cnt[c] = tick_cnt[c] - 8'd1;
            if (tick_cnt[c] == 8'd0) begin
               if (cur > 0) cur--;
               tick_cnt[c] = step_div[c];
            end
         end
         if (cur < goal) cur = goal;
         pos_now[c] = 8'(cur);
         if (cur <= mid && short_of_mid)
            step_out.push_back(mk_rsp(c, KIND_MIDWAY, ev, 1'b0, cur, 0, 1'b0));
      end
      if (goal == cur) begin
         mstate[c]     = MS_STOPPED;
         idle_polls[c] = 8'd0;
         step_out.push_back(mk_rsp(c, (cur == int'(home_pos[c])) ? KIND_AT_START : KIND_AT_END,
                                   ~ev, 1'b1, cur, 0, 1'b0));
      end
   endtask

   // Update the table for one accepted request word and collect its response words
   task automatic apply_word(input req_word_type w);
      int c;
      int ticks;
      logic [7:0] spd;
      c = int'(w.channel);
      step_out.delete();
      case (w.req_type)
         REQ_POLL: ramp_poll(c);
         REQ_MOVE: begin
            spd          = w.action_on ? w.speed_start_to_end : w.speed_end_to_start;
            home_pos[c]  = w.start_pos;
            far_pos[c]   = w.end_pos;
            fl_evinv[c]  = w.event_inverted;
            fl_cutoff[c] = w.cutoff_enable;
            fl_ext[c]    = w.extended_travel;
            pos_goal[c]  = (w.action_on ^ w.trigger_inverted) ? w.end_pos : w.start_pos;
            if (spd > cfg_pivot) begin
               step_inc[c] = spd - cfg_pivot;
               step_div[c] = 8'd0;
            end else begin
               step_div[c] = cfg_pivot - spd + 8'd1;
               tick_cnt[c] = 8'd1;
               step_inc[c] = 8'd0;
            end
            mstate[c] = MS_STARTING;
         end
         REQ_SETPOS: begin
            pos_now[c]  = w.position;
            pos_goal[c] = w.position;
         end
         default: begin
            if (fl_ext[c]) ticks = int'(PW_EXT_OFFSET) + int'(PW_EXT_SLOPE) * int'(pos_now[c]);
            else ticks = int'(PW_STD_OFFSET) + int'(PW_STD_SLOPE) * int'(pos_now[c]);
            step_out.push_back(mk_rsp(c, KIND_PULSE, 1'b0, 1'b0, int'(pos_now[c]),
                                      int'(PW_RELOAD_TOP) - ticks, mstate[c] != MS_OFF));
         end
      endcase
      if (step_out.size() != 0) step_out[$].last = 1'b1;
   endtask

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Speeds mostly above the pivot or at or just below it so that moves finish within a few polls
   function automatic logic [7:0] pick_speed();
      int r;
      int s;
      r = $urandom_range(0, 99);
      if (r < 55 && cfg_pivot < 8'd255) s = int'($urandom_range(int'(cfg_pivot) + 1, 255));
      else if (r < 85) begin
         s = int'(cfg_pivot) - int'($urandom_range(0, 3));
         if (s < 0) s = 0;
      end else s = int'($urandom_range(0, 255));
      return 8'(s);
   endfunction

   function automatic req_word_type gen_word();
      req_word_type w;
      logic [63:0]  raw;
      int r;
      int e;
      raw       = {$urandom(), $urandom()};
      w         = raw[$bits(req_word_type)-1:0];
      w.channel = ($urandom_range(0, 4) != 0) ? hot[$urandom_range(0, 3)]
                                              : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 20) begin
         w.req_type = REQ_MOVE;
         r = $urandom_range(0, 9);
         if (r == 0) w.start_pos = 8'($urandom_range(0, 1) * 255);
         if (r < 5) begin
            e = int'(w.start_pos) + int'($urandom_range(0, 60)) - 30;
            w.end_pos = 8'((e < 0) ? 0 : (e > 255) ? 255 : e);
         end
         w.speed_start_to_end = pick_speed();
         w.speed_end_to_start = pick_speed();
      end else if (r < 75) w.req_type = REQ_POLL;
      else if (r < 88) w.req_type = REQ_PULSE;
      else w.req_type = REQ_SETPOS;
      return w;
   endfunction

   // Present a request word at the falling edge and wait for it to be taken
   task automatic send_req(input req_word_type w, input bit typed, input rsp_word_type want);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.req_type           = w.req_type;
      req_if.channel            = w.channel;
      req_if.action_on          = w.action_on;
      req_if.start_pos          = w.start_pos;
      req_if.end_pos            = w.end_pos;
      req_if.speed_start_to_end = w.speed_start_to_end;
      req_if.speed_end_to_start = w.speed_end_to_start;
      req_if.trigger_inverted   = w.trigger_inverted;
      req_if.event_inverted     = w.event_inverted;
      req_if.cutoff_enable      = w.cutoff_enable;
      req_if.extended_travel    = w.extended_travel;
      req_if.position           = w.position;
      req_if.valid              = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      apply_word(w);
      if (typed) pending_rsp.push_back(want);
      else foreach (step_out[i]) pending_rsp.push_back(step_out[i]);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] val);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = val;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_SPEED_PIVOT) cfg_pivot = val;
      else cfg_cutoff = val;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Stop sending, wait for every expected word, then let the pipeline empty
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      hold_rsp     = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp > 0) begin
            rsp_if.ready = 1'b0;
            hold_rsp--;
         end else begin
            hold_rsp     = pick_gap();
            rsp_if.ready = (hold_rsp == 0);
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_channel, rsp_if.result_kind, rsp_if.evt_polarity,
                 rsp_if.save_position, rsp_if.current_position, rsp_if.pulse_reload,
                 rsp_if.pulse_enable, rsp_if.last};
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected word %0d on channel %0d", n_rsp, got.out_channel));
         end else begin
            want_now = pending_rsp.pop_front();
            check_field("out_channel", int'(got.out_channel), int'(want_now.out_channel));
            check_field("result_kind", int'(got.result_kind), int'(want_now.result_kind));
            check_field("evt_polarity", int'(got.evt_polarity), int'(want_now.evt_polarity));
            check_field("save_position", int'(got.save_position),
                        int'(want_now.save_position));
            check_field("current_position", int'(got.current_position),
                        int'(want_now.current_position));
            check_field("pulse_reload", int'(got.pulse_reload), int'(want_now.pulse_reload));
            check_field("pulse_enable", int'(got.pulse_enable), int'(want_now.pulse_enable));
            check_field("last", int'(got.last), int'(want_now.last));
         end
         n_rsp++;
      end
   end

   // Stimulus
   initial begin
      int counted;
      int phase_pivot  [NUM_PHASES];
      int phase_cutoff [NUM_PHASES];
      req_word_type w;
      phase_pivot  = '{1, 254, 40, 200, 97};
      phase_cutoff = '{1, 255, 2, 4, 1};
      errors = 0;
      n_rsp  = 0;
      cycles = 0;
      quiet  = 1'b0;
      reset  = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_POLL;
      {req_if.channel, req_if.action_on, req_if.start_pos, req_if.end_pos} = '0;
      {req_if.speed_start_to_end, req_if.speed_end_to_start, req_if.trigger_inverted} = '0;
      {req_if.event_inverted, req_if.cutoff_enable, req_if.extended_travel} = '0;
      req_if.position = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_SPEED_PIVOT;
      csr_if.data  = '0;

      // Predictor after reset
      cfg_pivot  = SPEED_PIVOT_RST;
      cfg_cutoff = CUTOFF_POLLS_RST;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         pos_now[c] = '0;  pos_goal[c] = '0;   mstate[c] = MS_OFF;
         step_inc[c] = '0; step_div[c] = '0;   tick_cnt[c] = '0;  idle_polls[c] = '0;
         home_pos[c] = '0; far_pos[c] = '0;
         fl_evinv[c] = 1'b0; fl_cutoff[c] = 1'b0; fl_ext[c] = 1'b0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pulse extremes, move already at target, stop on cutoff-enabled channel
      add_row(mk_req(REQ_PULSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(0, KIND_PULSE, 1'b0, 1'b0, 0, 61935, 1'b0, 1'b1));
      add_row(mk_req(REQ_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_SETPOS, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255), 1'b0, '0);
      add_row(mk_req(REQ_PULSE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(15, KIND_PULSE, 1'b0, 1'b0, 255, 57090, 1'b0, 1'b1));
      add_row(mk_req(REQ_MOVE, 15, 1, 0, 255, 255, 0, 0, 1, 1, 1, 0), 1'b0, '0);
      add_row(mk_req(REQ_PULSE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(15, KIND_PULSE, 1'b0, 1'b0, 255, 54955, 1'b1, 1'b1));
      add_row(mk_req(REQ_POLL, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0);
      add_row(mk_req(REQ_PULSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(0, KIND_PULSE, 1'b0, 1'b0, 0, 64135, 1'b1, 1'b1));
      // start, midway and stop from a single fast poll; then a slow move back
      add_row(mk_req(REQ_MOVE, 2, 1, 0, 100, 255, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_MOVE, 2, 0, 0, 100, 255, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // set position in mid-move keeps the motion state, next poll stops there
      add_row(mk_req(REQ_SETPOS, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 50), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // inverted trigger, speed equal to the pivot
      add_row(mk_req(REQ_MOVE, 3, 1, 200, 10, 128, 0, 1, 1, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // downward step larger than the position clamps at zero
      add_row(mk_req(REQ_SETPOS, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10), 1'b0, '0);
      add_row(mk_req(REQ_MOVE, 4, 0, 0, 200, 0, 255, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(mk_req(REQ_POLL, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // downward ramp over three polls crossing midway
      add_row(mk_req(REQ_SETPOS, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200), 1'b0, '0);
      add_row(mk_req(REQ_MOVE, 6, 0, 0, 200, 0, 200, 0, 0, 1, 0, 0), 1'b0, '0);
      repeat (3) add_row(mk_req(REQ_POLL, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

      foreach (dir_rows[i]) send_req(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // Random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(CSR_SPEED_PIVOT, 8'(phase_pivot[p]));
         csr_write(CSR_CUTOFF_POLLS, 8'(phase_cutoff[p]));
         quiet = (p == 2);
         foreach (hot[i]) hot[i] = 4'($urandom_range(0, 15));
         counted = 0;
         while (counted < PHASE_WORDS) begin
            w = gen_word();
            counted++;
            send_req(w, 1'b0, '0);
         end
         drain();
      end

      if (errors == 0) $display("tb_servo_motion_ramp_controller passed");
      else $display("tb_servo_motion_ramp_controller failed");
      $finish;
   end

endmodule
